[sv/sphat_pkg.sv]
// ----------------------------------------------------------------------------
// sphat_pkg - shared types and constants for the smoothed PHAT cross spectrum
// Pipeline lane types, fixed-point constants and default sizes.
// ----------------------------------------------------------------------------
package sphat_pkg;

    // Default store geometry
    localparam int PAIR_SLOTS_DEF = 16;
    localparam int FFT_LEN_DEF    = 512;

    // Smoothing factor 1.0 in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // Square root: one result bit per stage over a 64-bit radicand
    localparam int SQRT_STEPS = 32;
    // Division: quotient never exceeds 32768, so 17 quotient bits
    localparam int DIV_STEPS = 17;

    // Q1.15 output limits
    localparam logic [16:0] Q_POS_MAX = 17'd32767;
    localparam logic [16:0] Q_NEG_MAX = 17'd32768;

    // Control that travels with every word
    typedef struct packed {
        logic       valid;
        logic       live;
        logic [3:0] pair;
        logic [8:0] bin;
    } t_meta;

    // One square-root stage
    typedef struct packed {
        t_meta              meta;
        logic signed [31:0] sr;
        logic signed [31:0] si;
        logic [63:0]        rem;
        logic [63:0]        root;
    } t_sqrt_lane;

    // One division stage, real and imaginary lanes side by side
    typedef struct packed {
        t_meta       meta;
        logic [31:0] mag;
        logic [47:0] rem_r;
        logic [47:0] rem_i;
        logic [16:0] q_r;
        logic [16:0] q_i;
        logic        neg_r;
        logic        neg_i;
    } t_div_lane;

endpackage

[sv/smoothed_phat_cross_spectrum.sv]
// ----------------------------------------------------------------------------
// smoothed_phat_cross_spectrum - smoothed, phase-normalized cross spectrum
// Forms X1*conj(X2), blends it into a per-pair, per-bin store and returns
// the stored value divided by its magnitude in Q1.15.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      pair, bin, two complex bins
//  result    out        o_valid / i_stall      norm real/imag, pair, bin
//  config    in         i_cfg_wr_en            i_cfg_wr_data (smoothing)
//
//  One word enters per cycle while o_stall is low.
//  The depth is set by the 32-stage square root and the 17-stage divider.
//  After reset a clearing pass writes zero to all PAIR_SLOTS*(FFT_LEN/2+1)
//  store entries, one per cycle (4112 entries by default), with o_stall high.
//  A word whose store entry is still being updated by one of the previous
//  four words is held off until that write lands.
//  A two-deep output (register plus skid) keeps the input open while the
//  output stalls until a word is parked in the skid; the pipeline then holds.
// ----------------------------------------------------------------------------
module smoothed_phat_cross_spectrum #(
    parameter int PAIR_SLOTS = sphat_pkg::PAIR_SLOTS_DEF,
    parameter int FFT_LEN    = sphat_pkg::FFT_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [16:0]        i_cfg_wr_data,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_pair_slot,
    input  logic [8:0]         i_bin_slot,
    input  logic signed [23:0] i_first_real,
    input  logic signed [23:0] i_first_imag,
    input  logic signed [23:0] i_second_real,
    input  logic signed [23:0] i_second_imag,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_norm_real,
    output logic signed [15:0] o_norm_imag,
    output logic [3:0]         o_out_pair,
    output logic [8:0]         o_out_bin
);

    localparam int BIN_SLOTS   = FFT_LEN / 2 + 1;
    localparam int STORE_DEPTH = PAIR_SLOTS * BIN_SLOTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
    localparam int SQ_N = sphat_pkg::SQRT_STEPS;
    localparam int DV_N = sphat_pkg::DIV_STEPS;

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // One bit of the integer square root
    function automatic sphat_pkg::t_sqrt_lane sqrt_step(
        input sphat_pkg::t_sqrt_lane l, input int k);
        logic [63:0] bitv;
        logic [63:0] trial;
        sphat_pkg::t_sqrt_lane o;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = l.root + bitv;
        o     = l;
        if (l.rem >= trial) begin
            o.rem  = l.rem - trial;
            o.root = (l.root >> 1) + bitv;
        end else begin
            o.root = l.root >> 1;
        end
        return o;
    endfunction

    // One quotient bit of both restoring dividers
    function automatic sphat_pkg::t_div_lane div_step(
        input sphat_pkg::t_div_lane l, input int sh);
        logic [47:0] d;
        sphat_pkg::t_div_lane o;
        d = {16'd0, l.mag} << sh;
        o = l;
        if (l.rem_r >= d) begin
            o.rem_r   = l.rem_r - d;
            o.q_r[sh] = 1'b1;
        end
        if (l.rem_i >= d) begin
            o.rem_i   = l.rem_i - d;
            o.q_i[sh] = 1'b1;
        end
        return o;
    endfunction

    // Apply sign and Q1.15 limits to a quotient
    function automatic logic signed [15:0] to_q15(input logic [16:0] q, input logic neg);
        logic [16:0] t;
        if (neg) begin
            t = (q > sphat_pkg::Q_NEG_MAX) ? sphat_pkg::Q_NEG_MAX : q;
            t = 17'd0 - t;
        end else begin
            t = (q > sphat_pkg::Q_POS_MAX) ? sphat_pkg::Q_POS_MAX : q;
        end
        return t[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [16:0]        r_smooth;
    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_cnt;

    logic [63:0]        mem [STORE_DEPTH];
    logic [63:0]        r_rd;

    sphat_pkg::t_meta   r_a_meta, r_b_meta, r_c_meta, r_d_meta, r_e_meta;
    logic [ADDR_W-1:0]  r_a_idx, r_b_idx, r_c_idx, r_d_idx;
    logic signed [23:0] r_a_fr, r_a_fi, r_a_sr, r_a_si;
    logic signed [47:0] r_b_p1, r_b_p2, r_b_p3, r_b_p4;
    logic signed [31:0] r_b_old_r, r_b_old_i;
    logic signed [31:0] r_c_pr, r_c_pi, r_c_old_r, r_c_old_i;
    logic [16:0]        r_c_alpha, r_c_keep;
    logic signed [49:0] r_d_m1, r_d_m2, r_d_m3, r_d_m4;
    logic signed [31:0] r_e_sr, r_e_si;

    sphat_pkg::t_sqrt_lane r_sq [SQ_N+1];
    sphat_pkg::t_sqrt_lane n_sq [SQ_N+1];
    sphat_pkg::t_div_lane  r_dv [DV_N+1];
    sphat_pkg::t_div_lane  n_dv [DV_N+1];

    logic               r_ov, r_sk_valid;
    logic signed [15:0] r_out_r, r_out_i, r_sk_r, r_sk_i;
    logic [3:0]         r_out_pair, r_sk_pair;
    logic [8:0]         r_out_bin, r_sk_bin;

    logic [31:0]        in_idx_full;
    logic [ADDR_W-1:0]  in_idx;
    logic               in_live;
    logic               hazard;
    logic               en;
    logic               acc;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [63:0]        wr_data;
    logic signed [48:0] c_sum_r, c_sum_i;
    logic [16:0]        alpha_clamp;
    logic signed [17:0] keep_s, alpha_s;
    logic signed [50:0] e_sum_r, e_sum_i;
    logic signed [31:0] n_e_sr, n_e_si;
    logic signed [63:0] sq_r, sq_i;
    logic [31:0]        abs_r, abs_i, root_m;
    logic               tail_valid;
    logic signed [15:0] tail_r, tail_i;

    // ------------------------------------------------------------------
    // Input decode, hazard and flow control
    // ------------------------------------------------------------------
    assign in_idx_full = 32'(i_pair_slot) * 32'(BIN_SLOTS) + 32'(i_bin_slot);
    assign in_idx      = in_idx_full[ADDR_W-1:0];
    assign in_live     = (32'(i_pair_slot) < 32'(PAIR_SLOTS))
                      && (32'(i_bin_slot) < 32'(BIN_SLOTS));

    // hold a word whose entry is read before an earlier update is written
    assign hazard = in_live && (
        (r_a_meta.valid && r_a_meta.live && r_a_idx == in_idx) ||
        (r_b_meta.valid && r_b_meta.live && r_b_idx == in_idx) ||
        (r_c_meta.valid && r_c_meta.live && r_c_idx == in_idx) ||
        (r_d_meta.valid && r_d_meta.live && r_d_idx == in_idx));

    assign en      = !r_sk_valid;
    assign o_stall = r_clr_busy || !en || hazard;
    assign acc     = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Configuration and clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth   <= sphat_pkg::ALPHA_ONE;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_smooth <= i_cfg_wr_data;
            end
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Store: one write port, one registered read port
    // ------------------------------------------------------------------
    assign wr_en   = r_clr_busy || (en && r_d_meta.valid && r_d_meta.live);
    assign wr_addr = r_clr_busy ? r_clr_cnt : r_d_idx;
    assign wr_data = r_clr_busy ? 64'd0 : {n_e_sr, n_e_si};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (en) begin
            r_rd <= mem[in_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture word; stage B: cross products
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_meta.valid <= 1'b0;
            r_b_meta.valid <= 1'b0;
        end else if (en) begin
            r_a_meta <= '{valid: acc, live: in_live, pair: i_pair_slot, bin: i_bin_slot};
            r_a_idx  <= in_idx;
            r_a_fr   <= i_first_real;
            r_a_fi   <= i_first_imag;
            r_a_sr   <= i_second_real;
            r_a_si   <= i_second_imag;

            r_b_meta  <= r_a_meta;
            r_b_idx   <= r_a_idx;
            r_b_p1    <= r_a_fr * r_a_sr;
            r_b_p2    <= r_a_fi * r_a_si;
            r_b_p3    <= r_a_fi * r_a_sr;
            r_b_p4    <= r_a_fr * r_a_si;
            r_b_old_r <= r_rd[63:32];
            r_b_old_i <= r_rd[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: scale the product; stage D: blend products
    // ------------------------------------------------------------------
    assign c_sum_r     = 49'(r_b_p1) + 49'(r_b_p2);
    assign c_sum_i     = 49'(r_b_p3) - 49'(r_b_p4);
    assign alpha_clamp = (r_smooth > sphat_pkg::ALPHA_ONE) ? sphat_pkg::ALPHA_ONE : r_smooth;
    assign keep_s      = $signed({1'b0, r_c_keep});
    assign alpha_s     = $signed({1'b0, r_c_alpha});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_meta.valid <= 1'b0;
            r_d_meta.valid <= 1'b0;
        end else if (en) begin
            r_c_meta  <= r_b_meta;
            r_c_idx   <= r_b_idx;
            r_c_pr    <= sat32(35'($signed(c_sum_r[48:16])));
            r_c_pi    <= sat32(35'($signed(c_sum_i[48:16])));
            r_c_old_r <= r_b_old_r;
            r_c_old_i <= r_b_old_i;
            r_c_alpha <= alpha_clamp;
            r_c_keep  <= sphat_pkg::ALPHA_ONE - alpha_clamp;

            r_d_meta <= r_c_meta;
            r_d_idx  <= r_c_idx;
            r_d_m1   <= keep_s * r_c_old_r;
            r_d_m2   <= alpha_s * r_c_pr;
            r_d_m3   <= keep_s * r_c_old_i;
            r_d_m4   <= alpha_s * r_c_pi;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: new smoothed value, written to the store on the same edge
    // ------------------------------------------------------------------
    assign e_sum_r = 51'(r_d_m1) + 51'(r_d_m2);
    assign e_sum_i = 51'(r_d_m3) + 51'(r_d_m4);
    assign n_e_sr  = sat32($signed(e_sum_r[50:16]));
    assign n_e_si  = sat32($signed(e_sum_i[50:16]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_meta.valid <= 1'b0;
        end else if (en) begin
            r_e_meta <= r_d_meta;
            r_e_sr   <= n_e_sr;
            r_e_si   <= n_e_si;
        end
    end

    // ------------------------------------------------------------------
    // Squared magnitude, square root and division stages
    // ------------------------------------------------------------------
    assign sq_r   = r_e_sr * r_e_sr;
    assign sq_i   = r_e_si * r_e_si;
    assign root_m = r_sq[SQ_N].root[31:0];
    assign abs_r  = r_sq[SQ_N].sr[31] ? (~r_sq[SQ_N].sr + 32'd1) : r_sq[SQ_N].sr;
    assign abs_i  = r_sq[SQ_N].si[31] ? (~r_sq[SQ_N].si + 32'd1) : r_sq[SQ_N].si;

    always_comb begin
        // squared magnitude; a zero value drops to a zero result
        n_sq[0].meta       = r_e_meta;
        n_sq[0].meta.live  = r_e_meta.live && (r_e_sr != 32'sd0 || r_e_si != 32'sd0);
        n_sq[0].sr         = r_e_sr;
        n_sq[0].si         = r_e_si;
        n_sq[0].rem        = 64'(sq_r) + 64'(sq_i);
        n_sq[0].root       = 64'd0;
        for (int k = 0; k < SQ_N; k++) begin
            n_sq[k+1] = sqrt_step(r_sq[k], k);
        end

        // numerators with half the divisor added for rounding
        n_dv[0].meta  = r_sq[SQ_N].meta;
        n_dv[0].mag   = root_m;
        n_dv[0].rem_r = (48'(abs_r) << 15) + 48'(root_m >> 1);
        n_dv[0].rem_i = (48'(abs_i) << 15) + 48'(root_m >> 1);
        n_dv[0].q_r   = 17'd0;
        n_dv[0].q_i   = 17'd0;
        n_dv[0].neg_r = r_sq[SQ_N].sr[31];
        n_dv[0].neg_i = r_sq[SQ_N].si[31];
        for (int k = 0; k < DV_N; k++) begin
            n_dv[k+1] = div_step(r_dv[k], DV_N - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_N; k++) begin
                r_sq[k].meta.valid <= 1'b0;
            end
            for (int k = 0; k <= DV_N; k++) begin
                r_dv[k].meta.valid <= 1'b0;
            end
        end else if (en) begin
            r_sq <= n_sq;
            r_dv <= n_dv;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid
    // ------------------------------------------------------------------
    assign tail_valid = r_dv[DV_N].meta.valid;
    assign tail_r = r_dv[DV_N].meta.live ? to_q15(r_dv[DV_N].q_r, r_dv[DV_N].neg_r) : 16'sd0;
    assign tail_i = r_dv[DV_N].meta.live ? to_q15(r_dv[DV_N].q_i, r_dv[DV_N].neg_i) : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov       <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            // refill the output, skid first
            if (r_sk_valid) begin
                r_ov       <= 1'b1;
                r_sk_valid <= 1'b0;
                r_out_r    <= r_sk_r;
                r_out_i    <= r_sk_i;
                r_out_pair <= r_sk_pair;
                r_out_bin  <= r_sk_bin;
            end else begin
                r_ov       <= tail_valid;
                r_out_r    <= tail_r;
                r_out_i    <= tail_i;
                r_out_pair <= r_dv[DV_N].meta.pair;
                r_out_bin  <= r_dv[DV_N].meta.bin;
            end
        end else if (en && tail_valid) begin
            // park the word that leaves the pipeline while the output holds
            r_sk_valid <= 1'b1;
            r_sk_r     <= tail_r;
            r_sk_i     <= tail_i;
            r_sk_pair  <= r_dv[DV_N].meta.pair;
            r_sk_bin   <= r_dv[DV_N].meta.bin;
        end
    end

    assign o_valid     = r_ov;
    assign o_norm_real = r_out_r;
    assign o_norm_imag = r_out_i;
    assign o_out_pair  = r_out_pair;
    assign o_out_bin   = r_out_bin;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_ov)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_ov && i_stall))
        else $error("skid filled without an output stall");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_d_meta.valid)
        else $error("store update collides with the clearing pass");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && 32'(o_out_pair) >= 32'(PAIR_SLOTS))
            |-> (o_norm_real == 16'sd0 && o_norm_imag == 16'sd0))
        else $error("out-of-range pair gave a nonzero result");

endmodule
